### rtl/hffg_pkg.sv
// Shared types and constants for the hispeed-first frequency governor.
package hffg_pkg;

  localparam int unsigned FREQ_WIDTH = 22;
  localparam int unsigned PCT_WIDTH  = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PCT_DIV    = 100;

  localparam logic [PCT_WIDTH-1:0] UP_THR_RST   = 7'd85;
  localparam logic [PCT_WIDTH-1:0] DN_THR_RST   = 7'd40;
  localparam logic [PCT_WIDTH-1:0] HISP_PCT_RST = 7'd78;
  localparam logic [PCT_WIDTH-1:0] RAMP_PCT_RST = 7'd20;
  localparam logic [31:0]          MAX_FREQ_RST = 32'd2000000;
  localparam logic [31:0]          MIN_FREQ_RST = 32'd300000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UP_THR   = 3'd0,
    CFG_DN_THR   = 3'd1,
    CFG_HISP_PCT = 3'd2,
    CFG_RAMP_PCT = 3'd3,
    CFG_MAX_FREQ = 3'd4,
    CFG_MIN_FREQ = 3'd5
  } cfg_idx_e;

endpackage

### rtl/hispeed_first_frequency_governor.sv
// Hispeed-first load-based frequency governor, top level.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: start_req; tdata: load_pct, cur_freq
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser: relation_high; tdata: target_freq
//  cfg      | in  | cfg_we_i (no wait)           | cfg_idx_i, cfg_wdata_i
//
// One item per cycle unless a config write or output stall holds; input, then output register.
// Hispeed and ramp steps follow the config registers through two register stages
// (pct * max, then divide by 100 as a shift by two and a reciprocal multiply for 25):
// s_axis_tready is low during reset, in the first cycle after it and in the cycle after
// each config write.
// A stalled output holds; the input register keeps taking items while the output is free.
module hispeed_first_frequency_governor #(
  parameter int unsigned FreqWidth = hffg_pkg::FREQ_WIDTH,
  localparam int unsigned InDataW  = ((FreqWidth + hffg_pkg::PCT_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((FreqWidth + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hffg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FreqWidth-1:0]           cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [InDataW-1:0]             s_axis_tdata,  // load_pct, cur_freq, zero pad
  input  logic                           s_axis_tuser,  // start_req
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OutDataW-1:0]            m_axis_tdata,  // target_freq, zero pad
  output logic                           m_axis_tuser   // relation_high
);

  localparam int unsigned PctW  = hffg_pkg::PCT_WIDTH;
  localparam int unsigned ProdW = FreqWidth + PctW;
  localparam int unsigned QuarW = ProdW - 2;
  localparam int unsigned RecK  = QuarW + 5;
  localparam int unsigned RecW  = RecK - 4;
  localparam int unsigned QuoW  = FreqWidth + 1;
  localparam int unsigned MulW  = QuarW + RecW;
  localparam longint unsigned DivQuarter = hffg_pkg::PCT_DIV / 4;
  localparam logic [RecW-1:0] Recip =
    RecW'(((64'd1 << RecK) + DivQuarter - 1) / DivQuarter);

  // configuration registers
  logic [PctW-1:0]      up_thr_q, dn_thr_q, hisp_pct_q, ramp_pct_q;
  logic [FreqWidth-1:0] max_q, min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_thr_q   <= hffg_pkg::UP_THR_RST;
      dn_thr_q   <= hffg_pkg::DN_THR_RST;
      hisp_pct_q <= hffg_pkg::HISP_PCT_RST;
      ramp_pct_q <= hffg_pkg::RAMP_PCT_RST;
      max_q      <= hffg_pkg::MAX_FREQ_RST[FreqWidth-1:0];
      min_q      <= hffg_pkg::MIN_FREQ_RST[FreqWidth-1:0];
    end else if (cfg_we_i) begin
      unique case (hffg_pkg::cfg_idx_e'(cfg_idx_i))
        hffg_pkg::CFG_UP_THR:   up_thr_q   <= cfg_wdata_i[PctW-1:0];
        hffg_pkg::CFG_DN_THR:   dn_thr_q   <= cfg_wdata_i[PctW-1:0];
        hffg_pkg::CFG_HISP_PCT: hisp_pct_q <= cfg_wdata_i[PctW-1:0];
        hffg_pkg::CFG_RAMP_PCT: ramp_pct_q <= cfg_wdata_i[PctW-1:0];
        hffg_pkg::CFG_MAX_FREQ: max_q      <= cfg_wdata_i;
        hffg_pkg::CFG_MIN_FREQ: min_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // step recompute: product, then x / 100 = ((x >> 2) * Recip) >> RecK
  logic             cfg_busy_q;
  logic [ProdW-1:0] hprod_q, rprod_q;
  logic [MulW-1:0]  hmul, rmul;
  logic [QuoW-1:0]  hquo_q, rquo_q;

  assign hmul = {{RecW{1'b0}}, hprod_q[ProdW-1:2]} * {{QuarW{1'b0}}, Recip};
  assign rmul = {{RecW{1'b0}}, rprod_q[ProdW-1:2]} * {{QuarW{1'b0}}, Recip};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_busy_q <= 1'b1;
    end else begin
      cfg_busy_q <= cfg_we_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hprod_q <= {{FreqWidth{1'b0}}, hisp_pct_q} * {{PctW{1'b0}}, max_q};
    rprod_q <= {{FreqWidth{1'b0}}, ramp_pct_q} * {{PctW{1'b0}}, max_q};
    hquo_q  <= hmul[RecK +: QuoW];
    rquo_q  <= rmul[RecK +: QuoW];
  end

  // quotients stay below 1.27 * 2^FreqWidth
  logic [FreqWidth-1:0] hisp, step_dn;
  logic [FreqWidth:0]   step_up;

  assign hisp    = (hquo_q > {1'b0, max_q}) ? max_q : hquo_q[FreqWidth-1:0];
  assign step_up = rquo_q;
  assign step_dn = rquo_q[FreqWidth:1];

  // input register
  logic                 s1_valid_q, s1_start_q;
  logic [PctW-1:0]      s1_load_q;
  logic [FreqWidth-1:0] s1_cur_q;
  logic                 m_valid_q, m_rel_q;
  logic [FreqWidth-1:0] m_freq_q;
  logic                 adv, in_acc;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !cfg_busy_q && (!s1_valid_q || adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_start_q <= s_axis_tuser;
      s1_load_q  <= s_axis_tdata[PctW-1:0];
      s1_cur_q   <= s_axis_tdata[PctW+FreqWidth-1:PctW];
    end
  end

  // governor step
  logic [FreqWidth-1:0] req_q, req_d, req0, req1, res, dn_diff;
  logic                 mark_q, mark_d, mark0, mark1;
  logic                 up, dn, has_res;
  logic [FreqWidth+1:0] sum;

  always_comb begin
    req0    = s1_start_q ? s1_cur_q : req_q;
    mark0   = s1_start_q ? 1'b0 : mark_q;
    req1    = req0;
    mark1   = mark0;
    if (req0 > max_q || req0 < min_q) begin
      req1  = s1_cur_q;
      mark1 = 1'b0;
    end
    up      = s1_load_q > up_thr_q;
    dn      = s1_load_q < dn_thr_q;
    sum     = {2'b00, req1} + {1'b0, step_up};
    dn_diff = req1 - step_dn;
    res     = req1;
    has_res = 1'b0;
    req_d   = req0;
    mark_d  = mark1;
    if (up) begin
      has_res = 1'b1;
      if (!mark1 && req1 < hisp) begin
        res    = hisp;
        mark_d = 1'b1;
      end else begin
        res    = (sum > {2'b00, max_q}) ? max_q : sum[FreqWidth-1:0];
        mark_d = (sum >= {2'b00, max_q}) ? 1'b0 : mark1;
      end
      req_d = res;
    end else if (dn) begin
      has_res = 1'b1;
      mark_d  = 1'b0;
      res     = (req1 < step_dn || dn_diff < min_q) ? min_q : dn_diff;
      req_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q     <= '0;
      mark_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= s1_valid_q && has_res;
      if (s1_valid_q) begin
        req_q  <= req_d;
        mark_q <= mark_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      m_freq_q <= res;
      m_rel_q  <= up;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutDataW'(m_freq_q);
  assign m_axis_tuser  = m_rel_q;

endmodule

### rtl/hffg_chk.sv
// Port-level checks for the frequency governor, bound to the top level.
module hffg_chk #(
  parameter int unsigned FreqWidth = hffg_pkg::FREQ_WIDTH,
  localparam int unsigned InDataW  = ((FreqWidth + hffg_pkg::PCT_WIDTH + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((FreqWidth + 7) / 8) * 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input taken during step recompute");

  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid ##1 m_axis_tvalid |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching item");

  a_no_data_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata))
    else $error("accepted item has unknown data");

endmodule

bind hispeed_first_frequency_governor hffg_chk #(.FreqWidth(FreqWidth)) u_hffg_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/sv/tb.sv
// Self-checking testbench for the hispeed-first frequency governor.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FW        = hffg_pkg::FREQ_WIDTH;
  localparam int unsigned PW        = hffg_pkg::PCT_WIDTH;
  localparam int unsigned IW        = hffg_pkg::CFG_IDX_W;
  localparam int unsigned IN_W      = ((FW + PW + 7) / 8) * 8;
  localparam int unsigned OUT_W     = ((FW + 7) / 8) * 8;
  localparam longint unsigned FMASK = (64'd1 << FW) - 1;
  localparam int unsigned FTOP      = 32'(FMASK);
  localparam logic [IW-1:0] CFG_IDX_SPARE = 3'd6;
  localparam logic [IW-1:0] CFG_IDX_TOP   = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 65;

  typedef struct {
    logic [FW-1:0] target_freq;
    logic          relation_high;
  } freq_request_t;

  class hffg_scoreboard;
    int unsigned     errors;
    longint unsigned up_thr, dn_thr, hisp_pct, ramp_pct, max_f, min_f;
    longint unsigned requested;
    bit              hisp_mark;
    freq_request_t   requests_q[$];

    function new();
      up_thr    = hffg_pkg::UP_THR_RST;
      dn_thr    = hffg_pkg::DN_THR_RST;
      hisp_pct  = hffg_pkg::HISP_PCT_RST;
      ramp_pct  = hffg_pkg::RAMP_PCT_RST;
      max_f     = hffg_pkg::MAX_FREQ_RST[FW-1:0];
      min_f     = hffg_pkg::MIN_FREQ_RST[FW-1:0];
      requested = 0;
      hisp_mark = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [IW-1:0] idx, logic [FW-1:0] val);
      case (idx)
        hffg_pkg::CFG_UP_THR:   up_thr   = val[PW-1:0];
        hffg_pkg::CFG_DN_THR:   dn_thr   = val[PW-1:0];
        hffg_pkg::CFG_HISP_PCT: hisp_pct = val[PW-1:0];
        hffg_pkg::CFG_RAMP_PCT: ramp_pct = val[PW-1:0];
        hffg_pkg::CFG_MAX_FREQ: max_f    = val;
        hffg_pkg::CFG_MIN_FREQ: min_f    = val;
        default: ;
      endcase
    endfunction

    // accepted sample tick: advance governor state, queue any frequency request
    function void note_tick(bit start, logic [PW-1:0] load, logic [FW-1:0] cur);
      longint unsigned r, hisp, stp;
      freq_request_t   e;
      if (start) begin
        requested = cur;
        hisp_mark = 0;
      end
      r    = requested;
      hisp = (hisp_pct * max_f) / 100;
      if (hisp > max_f) hisp = max_f;
      if (r > max_f || r < min_f) begin
        r = cur;
        hisp_mark = 0;
      end
      if (load > up_thr) begin
        if (!hisp_mark && r < hisp) begin
          r = hisp;
          hisp_mark = 1;
        end else begin
          stp = (ramp_pct * max_f) / 100;
          r += stp;
          if (r > max_f) r = max_f;
          if (r == max_f) hisp_mark = 0;
        end
        r &= FMASK;
        requested = r;
        e.target_freq   = r[FW-1:0];
        e.relation_high = 1'b1;
        requests_q.push_back(e);
      end else if (load < dn_thr) begin
        hisp_mark = 0;
        stp = (ramp_pct * max_f) / 200;
        if (r < stp || r - stp < min_f) r = min_f;
        else r -= stp;
        r &= FMASK;
        requested = r;
        e.target_freq   = r[FW-1:0];
        e.relation_high = 1'b0;
        requests_q.push_back(e);
      end
    endfunction

    function void check_request(logic [FW-1:0] target, logic rel);
      freq_request_t e;
      if (requests_q.size() == 0) begin
        $display("%0t: unexpected request target_freq %0d relation_high %0b",
                 $time, target, rel);
        errors++;
        return;
      end
      e = requests_q.pop_front();
      if (target !== e.target_freq) begin
        $display("%0t: target_freq expected %0d actual %0d", $time, e.target_freq, target);
        errors++;
      end
      if (rel !== e.relation_high) begin
        $display("%0t: relation_high expected %0b actual %0b", $time, e.relation_high, rel);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IW-1:0]    cfg_idx_i;
  logic [FW-1:0]    cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  hffg_scoreboard sb = new();
  bit             calm;
  int unsigned    idle_cycles;

  hispeed_first_frequency_governor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PW-1:0] pick_load();
    int unsigned r, hi;
    r = $urandom_range(0, 99);
    if (r < 40 && sb.up_thr < 127) begin
      hi = (sb.up_thr < 100) ? 100 : 127;
      if ($urandom_range(0, 9) == 0) hi = 127;
      return PW'($urandom_range(32'(sb.up_thr) + 1, hi));
    end
    if (r < 80 && sb.dn_thr > 0) return PW'($urandom_range(0, 32'(sb.dn_thr) - 1));
    return PW'($urandom_range(0, 127));
  endfunction

  function automatic logic [FW-1:0] pick_window_freq();
    if (sb.min_f <= sb.max_f && $urandom_range(0, 9) != 0)
      return FW'($urandom_range(32'(sb.min_f), 32'(sb.max_f)));
    return FW'($urandom_range(0, FTOP));
  endfunction

  task automatic send_tick(bit start, logic [PW-1:0] load, logic [FW-1:0] cur);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start;
    s_axis_tdata  <= IN_W'({cur, load});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(start, load, cur);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.requests_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [IW-1:0] idx, logic [FW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // percent registers: upper write-data bits are don't-care, toggle them at random
  function automatic logic [FW-1:0] pct_word(int unsigned v);
    logic [FW-PW-1:0] junk;
    junk = $urandom_range(0, 1) ? (FW-PW)'($urandom) : '0;
    return {junk, PW'(v)};
  endfunction

  task automatic apply_settings(int unsigned up, int unsigned dn, int unsigned hp,
                                int unsigned rp, int unsigned mx, int unsigned mn);
    cfg_write(hffg_pkg::CFG_UP_THR, pct_word(up));
    cfg_write(hffg_pkg::CFG_DN_THR, pct_word(dn));
    if ($urandom_range(0, 2) == 0)
      cfg_write($urandom_range(0, 1) ? CFG_IDX_SPARE : CFG_IDX_TOP, FW'($urandom));
    cfg_write(hffg_pkg::CFG_HISP_PCT, pct_word(hp));
    cfg_write(hffg_pkg::CFG_RAMP_PCT, pct_word(rp));
    cfg_write(hffg_pkg::CFG_MAX_FREQ, FW'(mx));
    cfg_write(hffg_pkg::CFG_MIN_FREQ, FW'(mn));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly start-then-follow sequences, some noise ticks
  task automatic run_traffic(int unsigned n);
    int unsigned cnt, len;
    logic [FW-1:0] cur;
    cnt  = 0;
    calm = ($urandom_range(0, 3) == 0);
    while (cnt < n) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick(1'($urandom_range(0, 1)), PW'($urandom_range(0, 127)),
                  FW'($urandom_range(0, FTOP)));
        cnt++;
      end else begin
        len = $urandom_range(4, 20);
        send_tick(1'b1, pick_load(), pick_window_freq());
        cnt++;
        for (int i = 1; i < len && cnt < n; i++) begin
          cur = ($urandom_range(0, 4) == 0) ? pick_window_freq() : sb.requested[FW-1:0];
          send_tick(1'b0, pick_load(), cur);
          cnt++;
        end
      end
    end
  endtask

  task automatic run_directed();
    send_tick(1'b1, 7'd100, 22'd1000000);
    send_tick(1'b0, 7'd100, 22'd0);
    send_tick(1'b0, 7'd100, 22'd0);
    send_tick(1'b0, 7'd100, 22'd0);
    send_tick(1'b0, 7'd50,  22'd0);
    send_tick(1'b0, 7'd85,  22'd0);
    send_tick(1'b0, 7'd40,  22'd0);
    send_tick(1'b0, 7'd39,  22'd0);
    send_tick(1'b0, 7'd0,   22'd0);
    send_tick(1'b1, 7'd0,   22'd310000);
    send_tick(1'b0, 7'd0,   22'd300000);
    send_tick(1'b1, 7'd100, 22'd0);
    send_tick(1'b1, 7'd50,  22'h3FFFFF);
    send_tick(1'b0, 7'd86,  22'd12345);
    send_tick(1'b1, 7'd127, 22'h3FFFFF);
    send_tick(1'b0, 7'd0,   22'd0);
    send_tick(1'b1, 7'd127, 22'd2000000);
    send_tick(1'b0, 7'd1,   22'd0);
    send_tick(1'b1, 7'd100, 22'd1999999);
    send_tick(1'b0, 7'd100, 22'd1999999);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_request(m_axis_tdata[FW-1:0], m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL hispeed_first_frequency_governor");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned g;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  end

  initial begin
    int unsigned mx;
    calm          = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = hffg_pkg::CFG_UP_THR;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_traffic(PHASE_ITEMS);
    drain();

    // extremes: wide open, closed, zero max, min above max, tiny window
    apply_settings(0, 127, 127, 127, 22'h3FFFFF, 0);
    run_traffic(PHASE_ITEMS);
    drain();
    apply_settings(127, 0, 1, 1, 22'h3FFFFF, 22'h3FFFFF);
    run_traffic(PHASE_ITEMS);
    drain();
    apply_settings(100, 1, 100, 100, 0, 0);
    run_traffic(PHASE_ITEMS);
    drain();
    apply_settings(50, 50, 60, 10, 1000, 5000);
    run_traffic(PHASE_ITEMS);
    drain();
    apply_settings(85, 40, 78, 20, 100, 10);
    run_traffic(PHASE_ITEMS);
    drain();

    for (int p = 0; p < 8; p++) begin
      mx = ($urandom_range(0, 2) != 0) ? $urandom_range(1000, FTOP) : $urandom_range(0, 999);
      apply_settings($urandom_range(0, 100), $urandom_range(1, 100), $urandom_range(1, 100),
                     $urandom_range(1, 100), mx,
                     ($urandom_range(0, 5) == 0) ? $urandom_range(0, FTOP)
                                                 : $urandom_range(0, mx / 2));
      run_traffic(PHASE_ITEMS);
      drain();
    end

    if (sb.errors == 0 && sb.requests_q.size() == 0) begin
      $display("PASS hispeed_first_frequency_governor");
    end else begin
      $display("FAIL hispeed_first_frequency_governor");
    end
    $finish;
  end

endmodule
